// File: rtl/hcs_pkg.sv
package hcs_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int KEY_W           = 31;
    localparam int CNT_W           = 9;
    localparam int OP_W            = 2;
    localparam int ST_W            = 3;
    localparam logic [CNT_W-1:0] BC_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [ST_W-1:0] ST_ABSENT    = 3'd4;
    localparam logic [ST_W-1:0] ST_DELETED   = 3'd5;

endpackage

// File: rtl/hcs_rem.sv
// Bit-serial restoring remainder, one dividend bit per cycle.
module hcs_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hcs_pkg::KEY_W-1:0]   i_dividend,
    input  logic [hcs_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [hcs_pkg::CNT_W-1:0]   o_rem
);
    import hcs_pkg::*;

    localparam int SW = $clog2(KEY_W);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_step;
    logic [KEY_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_next;

    always_comb begin
        w_trial = {r_rem, r_dvd[KEY_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            w_next = w_trial - {1'b0, r_div};
        end else begin
            w_next = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_W-2:0], 1'b0};
            r_rem <= w_next[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/chained_hash_set.sv
// Hash set of 31-bit keys with separate chaining. One transaction at a time:
// o_ready is high only while the sequencer is idle. The bucket is
// key % bucket_count, computed by a bit-serial remainder unit. A search,
// insert or delete then reads the bucket entry and walks its chain through
// the node memories, one node at a time, before an insert or delete updates
// the bucket and node links (a refused insert on a full table skips the
// walk). The result sits in an output register, so the next transaction
// may start while it waits.
// After reset and after every write of bucket_count the bucket table is
// swept clear, one bucket per cycle, all MAX_BUCKETS rows, with o_ready low.
// bucket_count 0 acts as 1, values above MAX_BUCKETS act as MAX_BUCKETS.
// Operation code 3 acts as a search.
module chained_hash_set #(
    parameter int MAX_BUCKETS = hcs_pkg::MAX_BUCKETS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hcs_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hcs_pkg::OP_W-1:0]    i_operation,
    input  logic [hcs_pkg::KEY_W-1:0]   i_key,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hcs_pkg::ST_W-1:0]    o_status,
    output logic [hcs_pkg::CNT_W-1:0]   o_stored_count
);
    import hcs_pkg::*;

    // BW addresses a memory row, NW also holds the null node (MAX_BUCKETS)
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW = $clog2(MAX_BUCKETS + 1);
    localparam logic [NW-1:0] NULL_NODE = NW'(MAX_BUCKETS);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_MOD   = 13'b0000000000100,
        S_BRD   = 13'b0000000001000,
        S_CHK   = 13'b0000000010000,
        S_WALK  = 13'b0000000100000,
        S_CMP   = 13'b0000001000000,
        S_ALLOC = 13'b0000010000000,
        S_INS1  = 13'b0000100000000,
        S_INS2  = 13'b0001000000000,
        S_DEL1  = 13'b0010000000000,
        S_DEL2  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    // memories
    logic [2*NW-1:0]  m_bkt  [MAX_BUCKETS];   // {first, last}
    logic [KEY_W-1:0] m_key  [MAX_BUCKETS];
    logic [NW-1:0]    m_link [MAX_BUCKETS];

    t_state           r_state, n_state;
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [BW-1:0]    r_bkt;
    logic [NW-1:0]    r_first, r_last, r_cur, r_prev, r_node, r_rec, r_hwm;
    logic [ST_W-1:0]  r_status;
    logic [CNT_W-1:0] r_cnt, r_bc;
    logic [BW-1:0]    r_clr;
    logic             r_ovalid;
    logic [ST_W-1:0]  r_ost;
    logic [CNT_W-1:0] r_ocnt;

    logic [2*NW-1:0]  r_bkt_rd;
    logic [KEY_W-1:0] r_key_rd;
    logic [NW-1:0]    r_link_rd;

    // memory controls
    logic             w_bkt_we, w_bkt_re;
    logic [BW-1:0]    w_bkt_wa;
    logic [2*NW-1:0]  w_bkt_wd;
    logic             w_key_we;
    logic             w_link_we, w_node_re;
    logic [NW-1:0]    w_link_wa, w_link_wd, w_node_ra, w_key_wa;

    logic             w_accept, w_rem_done, w_load_out;
    logic [CNT_W-1:0] w_rem, w_bc_new;

    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign w_load_out = (r_state == S_DONE) && (!r_ovalid || i_ready);

    hcs_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_key),
        .i_divisor  (r_bc),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_bc_new = CNT_W'(1);
        end else if (int'(i_cfg_wdata) > MAX_BUCKETS) begin
            w_bc_new = CNT_W'(MAX_BUCKETS);
        end else begin
            w_bc_new = i_cfg_wdata;
        end
    end

    // next state and memory port control
    always_comb begin
        n_state   = r_state;
        w_bkt_we  = 1'b0;
        w_bkt_re  = 1'b0;
        w_bkt_wa  = r_bkt;
        w_bkt_wd  = {NULL_NODE, NULL_NODE};
        w_key_we  = 1'b0;
        w_key_wa  = r_node;
        w_link_we = 1'b0;
        w_link_wa = r_node;
        w_link_wd = NULL_NODE;
        w_node_re = 1'b0;
        w_node_ra = r_cur;
        case (r_state)
            S_CLEAR: begin
                w_bkt_we = 1'b1;
                w_bkt_wa = r_clr;
                if (r_clr == BW'(MAX_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (w_rem_done) begin
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                w_bkt_re = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (r_op == OP_INSERT && r_cnt >= r_bc) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_cur == NULL_NODE) begin
                    if (r_op == OP_INSERT) begin
                        if (r_rec != NULL_NODE) begin
                            w_node_re = 1'b1;
                            w_node_ra = r_rec;
                            n_state   = S_ALLOC;
                        end else begin
                            n_state = S_INS1;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    w_node_re = 1'b1;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (r_key_rd == r_key) begin
                    if (r_op == OP_DELETE) begin
                        n_state = S_DEL1;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_ALLOC: begin
                n_state = S_INS1;
            end
            S_INS1: begin
                w_key_we  = 1'b1;
                w_link_we = 1'b1;
                w_bkt_we  = 1'b1;
                w_bkt_wd  = {(r_first == NULL_NODE) ? r_node : r_first, r_node};
                n_state   = S_INS2;
            end
            S_INS2: begin
                w_link_we = (r_last != NULL_NODE);
                w_link_wa = r_last;
                w_link_wd = r_node;
                n_state   = S_DONE;
            end
            S_DEL1: begin
                // unlink: predecessor (or bucket head) skips the node
                w_bkt_we  = 1'b1;
                w_bkt_wd  = {(r_prev == NULL_NODE) ? r_link_rd : r_first,
                             (r_last == r_cur) ? r_prev : r_last};
                w_link_we = (r_prev != NULL_NODE);
                w_link_wa = r_prev;
                w_link_wd = r_link_rd;
                n_state   = S_DEL2;
            end
            S_DEL2: begin
                // freed node goes on the recycle list
                w_link_we = 1'b1;
                w_link_wa = r_cur;
                w_link_wd = r_rec;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_bkt_we) begin
            m_bkt[w_bkt_wa] <= w_bkt_wd;
        end
        if (w_bkt_re) begin
            r_bkt_rd <= m_bkt[r_bkt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            m_key[w_key_wa[BW-1:0]] <= r_key;
        end
        if (w_node_re) begin
            r_key_rd <= m_key[w_node_ra[BW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            m_link[w_link_wa[BW-1:0]] <= w_link_wd;
        end
        if (w_node_re) begin
            r_link_rd <= m_link[w_node_ra[BW-1:0]];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_bc     <= (int'(BC_RESET) > MAX_BUCKETS) ? CNT_W'(MAX_BUCKETS) : BC_RESET;
            r_cnt    <= '0;
            r_hwm    <= '0;
            r_rec    <= NULL_NODE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_bc    <= w_bc_new;
                r_state <= S_CLEAR;
                r_clr   <= '0;
                r_cnt   <= '0;
                r_hwm   <= '0;
                r_rec   <= NULL_NODE;
            end else begin
                r_state <= n_state;
                if (r_state == S_CLEAR) begin
                    r_clr <= r_clr + 1'b1;
                end
                if (r_state == S_WALK && r_cur == NULL_NODE && r_op == OP_INSERT
                        && r_rec == NULL_NODE) begin
                    r_hwm <= r_hwm + 1'b1;
                end
                if (r_state == S_ALLOC) begin
                    r_rec <= r_link_rd;
                end
                if (r_state == S_DEL2) begin
                    r_rec <= r_cur;
                    r_cnt <= r_cnt - 1'b1;
                end
                if (r_state == S_INS2) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_key <= i_key;
        end
        if (r_state == S_MOD && w_rem_done) begin
            r_bkt <= BW'(w_rem);
        end
        case (r_state)
            S_CHK: begin
                r_first  <= r_bkt_rd[2*NW-1:NW];
                r_last   <= r_bkt_rd[NW-1:0];
                r_cur    <= r_bkt_rd[2*NW-1:NW];
                r_prev   <= NULL_NODE;
                r_status <= ST_FULL;
            end
            S_WALK: begin
                if (r_cur == NULL_NODE) begin
                    r_node   <= (r_rec != NULL_NODE) ? r_rec : r_hwm;
                    r_status <= (r_op == OP_INSERT) ? ST_INSERTED : ST_ABSENT;
                end
            end
            S_CMP: begin
                if (r_key_rd == r_key) begin
                    if (r_op == OP_INSERT) begin
                        r_status <= ST_DUPLICATE;
                    end else if (r_op == OP_DELETE) begin
                        r_status <= ST_DELETED;
                    end else begin
                        r_status <= ST_FOUND;
                    end
                end else begin
                    r_prev <= r_cur;
                    r_cur  <= r_link_rd;
                end
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_ost  <= r_status;
            r_ocnt <= r_cnt;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ost;
    assign o_stored_count = r_ocnt;

endmodule

// File: rtl/hcs_chk.sv
module hcs_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [hcs_pkg::ST_W-1:0]    o_status,
    input logic [hcs_pkg::CNT_W-1:0]   o_stored_count
);
    import hcs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_stored_count))
        else $error("result changed while stalled");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_DELETED)
        else $error("illegal status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INSERTED |-> o_stored_count != '0)
        else $error("insert reported with empty table");

endmodule

bind chained_hash_set hcs_chk u_hcs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_stored_count (o_stored_count)
);
